@@ design/peer_retry_backoff_scheduler_top_assert.svh @@
// Assertion macros for the peer retry backoff scheduler checker.
`ifndef PEER_RETRY_BACKOFF_SCHEDULER_TOP_ASSERT_SVH
`define PEER_RETRY_BACKOFF_SCHEDULER_TOP_ASSERT_SVH

// Clocked assertion, disabled in reset.
`define PRBS_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);

// Next-cycle implication built on the macro above.
`define PRBS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  `PRBS_ASSERT(lbl, ck, rs, (ante) |=> (cons), msg)

`endif

@@ design/prbs_pkg.sv @@
// Types, codes and constants shared by the peer retry backoff scheduler.
package prbs_pkg;

  localparam int OPC_W      = 2;
  localparam int MAC_W      = 48;
  localparam int LEN_W      = 10;
  localparam int TIME_W     = 32;
  localparam int RET_W      = 4;
  localparam int BASE_W     = 10;
  localparam int CAP_W      = 16;
  localparam int KIND_W     = 2;
  localparam int ERR_W      = 2;
  localparam int PIDX_W     = 3;
  localparam int SLEN_W     = 8;
  localparam int SHIFT_W    = BASE_W + (1 << RET_W) - 1;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int MAX_RESULTS = 8;
  localparam int EMIT_CNT_W  = $clog2(MAX_RESULTS + 1);

  localparam logic [OPC_W-1:0] OP_SEND     = 2'd0;
  localparam logic [OPC_W-1:0] OP_COMPLETE = 2'd1;
  localparam logic [OPC_W-1:0] OP_TICK     = 2'd2;

  localparam logic [KIND_W-1:0] KIND_TRANSMIT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RETRANSMIT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REJECT     = 2'd2;

  localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
  localparam logic [ERR_W-1:0] ERR_ZERO = 2'd1;
  localparam logic [ERR_W-1:0] ERR_LONG = 2'd2;
  localparam logic [ERR_W-1:0] ERR_FULL = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_CAP  = 2'd2;

  localparam logic [RET_W-1:0]  RETRY_LIMIT_RST  = 4'd5;
  localparam logic [BASE_W-1:0] BACKOFF_BASE_RST = 10'd30;
  localparam logic [CAP_W-1:0]  BACKOFF_CAP_RST  = 16'd500;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ERR_W-1:0]  error_code;
    logic [PIDX_W-1:0] peer_index;
    logic [MAC_W-1:0]  dest_mac;
    logic [SLEN_W-1:0] send_length;
    logic              last;
  } result_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic send_commit;
    logic comp_commit;
    logic tick_step;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic [OPC_W-1:0] op;
    logic             scan_last;
    logic             tick_emit;
    logic             pend_valid;
    logic             out_free;
    logic             emit_full;
  } dp_status_t;

endpackage

@@ design/prbs_dp.sv @@
// Datapath: configuration, peer slot table, backoff arithmetic and result registers.
module prbs_dp #(
  parameter int PEER_SLOTS  = 8,
  parameter int PAYLOAD_MAX = 250
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [prbs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [prbs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [prbs_pkg::OPC_W-1:0]        in_opcode,
  input  logic [prbs_pkg::MAC_W-1:0]        in_mac,
  input  logic [prbs_pkg::LEN_W-1:0]        in_length,
  input  logic                              in_send_ok,
  input  logic [prbs_pkg::TIME_W-1:0]       in_now,
  input  prbs_pkg::dp_cmd_t                 cmd,
  output prbs_pkg::dp_status_t              status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output prbs_pkg::result_t                 out_res
);

  localparam int IW  = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int SLW = $clog2(PAYLOAD_MAX + 1);

  logic [prbs_pkg::RET_W-1:0]  retry_limit;
  logic [prbs_pkg::BASE_W-1:0] backoff_base;
  logic [prbs_pkg::CAP_W-1:0]  backoff_cap;

  logic                         slot_used  [PEER_SLOTS];
  logic                         slot_armed [PEER_SLOTS];
  logic [prbs_pkg::MAC_W-1:0]   slot_mac   [PEER_SLOTS];
  logic [SLW-1:0]               slot_len   [PEER_SLOTS];
  logic [prbs_pkg::RET_W-1:0]   slot_rem   [PEER_SLOTS];
  logic [prbs_pkg::TIME_W-1:0]  slot_due   [PEER_SLOTS];

  logic [prbs_pkg::OPC_W-1:0]   item_op;
  logic [prbs_pkg::MAC_W-1:0]   item_mac;
  logic [prbs_pkg::LEN_W-1:0]   item_len;
  logic                         item_ok;
  logic [prbs_pkg::TIME_W-1:0]  item_now;

  logic [IW-1:0]                idx;
  logic                         hit;
  logic [IW-1:0]                hit_idx;
  logic                         free_hit;
  logic [IW-1:0]                free_idx;
  logic [prbs_pkg::EMIT_CNT_W-1:0] emit_cnt;

  logic                         pend_valid;
  prbs_pkg::result_t            pend;

  logic [IW-1:0]                rd;
  logic                         s_used;
  logic                         s_armed;
  logic [prbs_pkg::MAC_W-1:0]   s_mac;
  logic [SLW-1:0]               s_len;
  logic [prbs_pkg::RET_W-1:0]   s_rem;
  logic [prbs_pkg::TIME_W-1:0]  s_due;

  logic [prbs_pkg::TIME_W-1:0]  t_diff;
  logic                         t_consider;
  logic                         t_due;
  logic                         tick_emit;
  logic                         tick_disarm;
  logic [prbs_pkg::RET_W-1:0]   rem_dec;
  logic [prbs_pkg::RET_W-1:0]   c_rem;
  logic [prbs_pkg::RET_W-1:0]   d_rem;
  logic [prbs_pkg::CAP_W-1:0]   delay;
  logic [prbs_pkg::TIME_W-1:0]  new_due;
  logic [prbs_pkg::ERR_W-1:0]   send_err;
  logic [IW-1:0]                widx;
  logic                         out_free;

  function automatic logic [prbs_pkg::CAP_W-1:0] backoff(
    input logic [prbs_pkg::RET_W-1:0]  rem,
    input logic [prbs_pkg::RET_W-1:0]  maxr,
    input logic [prbs_pkg::BASE_W-1:0] base,
    input logic [prbs_pkg::CAP_W-1:0]  cap
  );
    logic [prbs_pkg::RET_W-1:0]   used_n;
    logic [prbs_pkg::SHIFT_W-1:0] v;
    used_n = maxr - rem;
    v = prbs_pkg::SHIFT_W'(base) << used_n;
    if (rem > maxr) begin
      return cap;
    end else if (v > prbs_pkg::SHIFT_W'(cap)) begin
      return cap;
    end else begin
      return v[prbs_pkg::CAP_W-1:0];
    end
  endfunction

  // one read port into the slot table
  assign rd      = cmd.comp_commit ? hit_idx : idx;
  assign s_used  = slot_used[rd];
  assign s_armed = slot_armed[rd];
  assign s_mac   = slot_mac[rd];
  assign s_len   = slot_len[rd];
  assign s_rem   = slot_rem[rd];
  assign s_due   = slot_due[rd];

  assign t_diff      = item_now - s_due;
  assign t_due       = !t_diff[prbs_pkg::TIME_W-1];
  assign t_consider  = s_used && s_armed;
  assign tick_emit   = t_consider && (s_len != '0) && t_due && (s_rem != '0);
  assign tick_disarm = t_consider && ((s_len == '0) || (t_due && (s_rem == '0)));
  assign rem_dec     = s_rem - prbs_pkg::RET_W'(1);
  assign c_rem       = (s_rem == '0) ? retry_limit : s_rem;
  assign d_rem       = cmd.comp_commit ? c_rem : rem_dec;
  assign delay       = backoff(d_rem, retry_limit, backoff_base, backoff_cap);
  assign new_due     = item_now + prbs_pkg::TIME_W'(delay);
  assign widx        = hit ? hit_idx : free_idx;
  assign out_free    = !out_valid || out_ready;

  always_comb begin
    priority if (item_len == '0) begin
      send_err = prbs_pkg::ERR_ZERO;
    end else if (item_len > prbs_pkg::LEN_W'(PAYLOAD_MAX)) begin
      send_err = prbs_pkg::ERR_LONG;
    end else if (!hit && !free_hit) begin
      send_err = prbs_pkg::ERR_FULL;
    end else begin
      send_err = prbs_pkg::ERR_NONE;
    end
  end

  assign status.op         = item_op;
  assign status.scan_last  = (idx == IW'(PEER_SLOTS - 1));
  assign status.tick_emit  = tick_emit;
  assign status.pend_valid = pend_valid;
  assign status.out_free   = out_free;
  assign status.emit_full  = (emit_cnt == prbs_pkg::EMIT_CNT_W'(prbs_pkg::MAX_RESULTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit  <= prbs_pkg::RETRY_LIMIT_RST;
      backoff_base <= prbs_pkg::BACKOFF_BASE_RST;
      backoff_cap  <= prbs_pkg::BACKOFF_CAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        prbs_pkg::CFG_RETRY_LIMIT:  retry_limit  <= cfg_data[prbs_pkg::RET_W-1:0];
        prbs_pkg::CFG_BACKOFF_BASE: backoff_base <= cfg_data[prbs_pkg::BASE_W-1:0];
        prbs_pkg::CFG_BACKOFF_CAP:  backoff_cap  <= cfg_data[prbs_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // slot flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PEER_SLOTS; i++) begin
        slot_used[i]  <= 1'b0;
        slot_armed[i] <= 1'b0;
      end
    end else begin
      if (cmd.send_commit && send_err == prbs_pkg::ERR_NONE) begin
        slot_used[widx]  <= 1'b1;
        slot_armed[widx] <= 1'b0;
      end
      if (cmd.comp_commit && hit) begin
        if (item_ok) begin
          slot_armed[hit_idx] <= 1'b0;
        end else if (s_len != '0) begin
          slot_armed[hit_idx] <= 1'b1;
        end
      end
      if (cmd.tick_step && tick_disarm) begin
        slot_armed[idx] <= 1'b0;
      end
    end
  end

  // slot payload
  always_ff @(posedge clk) begin
    if (cmd.send_commit && send_err == prbs_pkg::ERR_NONE) begin
      if (!hit) begin
        slot_mac[widx] <= item_mac;
      end
      slot_len[widx] <= SLW'(item_len);
      slot_rem[widx] <= '0;
      slot_due[widx] <= '0;
    end
    if (cmd.comp_commit && hit) begin
      if (item_ok) begin
        slot_rem[hit_idx] <= '0;
      end else if (s_len != '0) begin
        slot_rem[hit_idx] <= c_rem;
        slot_due[hit_idx] <= new_due;
      end
    end
    if (cmd.tick_step && tick_emit) begin
      slot_rem[idx] <= rem_dec;
      slot_due[idx] <= new_due;
    end
  end

  // item and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_op  <= in_opcode;
      item_mac <= in_mac;
      item_len <= in_length;
      item_ok  <= in_send_ok;
      item_now <= in_now;
      idx      <= '0;
      hit      <= 1'b0;
      free_hit <= 1'b0;
      emit_cnt <= '0;
    end else begin
      if (cmd.scan_step) begin
        if (!hit && s_used && s_mac == item_mac) begin
          hit     <= 1'b1;
          hit_idx <= idx;
        end
        if (!free_hit && !s_used) begin
          free_hit <= 1'b1;
          free_idx <= idx;
        end
        idx <= idx + IW'(1);
      end
      if (cmd.tick_step) begin
        if (tick_emit) begin
          emit_cnt <= emit_cnt + prbs_pkg::EMIT_CNT_W'(1);
        end
        idx <= idx + IW'(1);
      end
    end
  end

  // held retransmit and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.send_commit) begin
        out_valid        <= 1'b1;
        out_res.last     <= 1'b1;
        out_res.dest_mac <= item_mac;
        if (send_err == prbs_pkg::ERR_NONE) begin
          out_res.kind        <= prbs_pkg::KIND_TRANSMIT;
          out_res.error_code  <= prbs_pkg::ERR_NONE;
          out_res.peer_index  <= prbs_pkg::PIDX_W'(widx);
          out_res.send_length <= item_len[prbs_pkg::SLEN_W-1:0];
        end else begin
          out_res.kind        <= prbs_pkg::KIND_REJECT;
          out_res.error_code  <= send_err;
          out_res.peer_index  <= '0;
          out_res.send_length <= '0;
        end
      end else if (cmd.flush && pend_valid) begin
        out_valid           <= 1'b1;
        out_res.kind        <= pend.kind;
        out_res.error_code  <= pend.error_code;
        out_res.peer_index  <= pend.peer_index;
        out_res.dest_mac    <= pend.dest_mac;
        out_res.send_length <= pend.send_length;
        out_res.last        <= 1'b1;
      end else if (cmd.tick_step && tick_emit && pend_valid) begin
        out_valid <= 1'b1;
        out_res   <= pend;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.tick_step && tick_emit) begin
        pend_valid       <= 1'b1;
        pend.kind        <= prbs_pkg::KIND_RETRANSMIT;
        pend.error_code  <= prbs_pkg::ERR_NONE;
        pend.peer_index  <= prbs_pkg::PIDX_W'(idx);
        pend.dest_mac    <= s_mac;
        pend.send_length <= prbs_pkg::SLEN_W'(s_len);
        pend.last        <= 1'b0;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

endmodule

@@ design/prbs_ctrl.sv @@
// Controller: sequences the slot walk for each accepted send, completion or tick word.
module prbs_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [prbs_pkg::OPC_W-1:0]  in_opcode,
  input  prbs_pkg::dp_status_t        status,
  output prbs_pkg::dp_cmd_t           cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_TICK,
    S_FLUSH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (in_opcode)
            prbs_pkg::OP_SEND,
            prbs_pkg::OP_COMPLETE: state_next = S_SCAN;
            prbs_pkg::OP_TICK:     state_next = S_TICK;
            default:               state_next = S_FLUSH;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = S_ACT;
        end
      end
      S_ACT: begin
        if (status.op == prbs_pkg::OP_COMPLETE) begin
          cmd.comp_commit = 1'b1;
          state_next      = S_IDLE;
        end else if (status.out_free) begin
          cmd.send_commit = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_TICK: begin
        priority if (status.emit_full) begin
          state_next = S_FLUSH;
        end else if (status.tick_emit && status.pend_valid && !status.out_free) begin
          state_next = S_TICK;
        end else begin
          cmd.tick_step = 1'b1;
          if (status.scan_last) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!status.pend_valid) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ design/peer_retry_backoff_scheduler_top.sv @@
// Top level of the peer retry backoff scheduler.
// Takes one input word at a time. A send or completion walks the peer table one slot per
// cycle through the table's single read port and then commits; a send commits only once the
// output register is free, so it waits while an earlier result word waits for m_tready. A
// tick also walks the slots once, stopping early after MAX_RESULTS retransmits, and stalls
// while a held result waits for m_tready; an unused opcode walks no slots.
// Results leave through an output register, and a tick holds its newest retransmit one step
// so that the final one is marked with m_tlast. Configuration writes are always ready, and the
// user must keep them to idle periods only; the block itself does not enforce this.
module peer_retry_backoff_scheduler_top #(
  parameter int PEER_SLOTS  = 8,
  parameter int PAYLOAD_MAX = 250
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // peer_addr[47:0], length[57:48], send_ok[58], now_ms[90:59], zero fill
  input  logic [prbs_pkg::IN_DATA_W-1:0]   s_tdata,
  // opcode[1:0]
  input  logic [prbs_pkg::OPC_W-1:0]       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // error_code[1:0], peer_index[4:2], dest_mac[52:5], send_length[60:53], zero fill
  output logic [prbs_pkg::OUT_DATA_W-1:0]  m_tdata,
  // kind[1:0]
  output logic [prbs_pkg::KIND_W-1:0]      m_tuser,
  output logic                             m_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [prbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [prbs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  prbs_pkg::dp_cmd_t    cmd;
  prbs_pkg::dp_status_t status;
  prbs_pkg::result_t    res;

  assign cfg_ready = 1'b1;

  prbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_opcode (s_tuser),
    .status    (status),
    .cmd       (cmd)
  );

  prbs_dp #(
    .PEER_SLOTS  (PEER_SLOTS),
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_opcode  (s_tuser),
    .in_mac     (s_tdata[47:0]),
    .in_length  (s_tdata[57:48]),
    .in_send_ok (s_tdata[58]),
    .in_now     (s_tdata[90:59]),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_res    (res)
  );

  assign m_tdata = {3'b000, res.send_length, res.dest_mac, res.peer_index, res.error_code};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

endmodule

@@ design/prbs_checker.sv @@
// Port-level checker for the peer retry backoff scheduler, bound to the top level.
`include "peer_retry_backoff_scheduler_top_assert.svh"

module prbs_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [prbs_pkg::OUT_DATA_W-1:0]  m_tdata,
  input logic [prbs_pkg::KIND_W-1:0]      m_tuser,
  input logic                             m_tlast
);

  `PRBS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid, "result word dropped while stalled")
  `PRBS_ASSERT_NEXT(a_out_stable, clk, rst, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result word changed")
  `PRBS_ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready, "input taken while a word is in work")
  `PRBS_ASSERT(a_reject_form, clk, rst, (m_tvalid && (m_tuser == prbs_pkg::KIND_REJECT)) |-> (m_tlast && (m_tdata[4:2] == 3'd0) && (m_tdata[60:53] == 8'd0) && (m_tdata[1:0] != prbs_pkg::ERR_NONE)), "malformed reject word")
  `PRBS_ASSERT(a_transmit_form, clk, rst, (m_tvalid && (m_tuser == prbs_pkg::KIND_TRANSMIT)) |-> (m_tlast && (m_tdata[1:0] == prbs_pkg::ERR_NONE)), "malformed transmit word")

endmodule

bind peer_retry_backoff_scheduler_top prbs_checker u_prbs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

@@ test/peer_retry_backoff_scheduler_top_tb.sv @@
// Self-checking testbench for the peer retry backoff scheduler.
module peer_retry_backoff_scheduler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import prbs_pkg::*;

  localparam int PEER_SLOTS  = 8;
  localparam int PAYLOAD_MAX = 250;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 2 * PEER_SLOTS + 8;
  localparam logic [OPC_W-1:0] OP_RESERVED = 2'd3;

  typedef enum {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_BURSTY} rx_mode_t;

  class retry_scoreboard;
    result_t awaited_results[$];
    int errors;
    bit slot_used [PEER_SLOTS];
    bit [MAC_W-1:0] slot_mac [PEER_SLOTS];
    bit [SLEN_W-1:0] slot_len [PEER_SLOTS];
    bit armed [PEER_SLOTS];
    bit [RET_W-1:0] remaining [PEER_SLOTS];
    bit [TIME_W-1:0] due_at [PEER_SLOTS];
    bit [RET_W-1:0] retry_limit;
    bit [BASE_W-1:0] base_ms;
    bit [CAP_W-1:0] cap_ms;

    function new();
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_mac[i] = '0;
        slot_len[i] = '0;
        armed[i] = 1'b0;
        remaining[i] = '0;
        due_at[i] = '0;
      end
      retry_limit = RETRY_LIMIT_RST;
      base_ms = BACKOFF_BASE_RST;
      cap_ms = BACKOFF_CAP_RST;
      errors = 0;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_RETRY_LIMIT:  retry_limit = val[RET_W-1:0];
        CFG_BACKOFF_BASE: base_ms = val[BASE_W-1:0];
        CFG_BACKOFF_CAP:  cap_ms = val[CAP_W-1:0];
        default: ;
      endcase
    endfunction

    function bit [TIME_W-1:0] backoff_delay(bit [RET_W-1:0] rem);
      bit [63:0] v;
      int attempts;
      if (rem > retry_limit) return TIME_W'(cap_ms);
      attempts = retry_limit - rem;
      v = 64'(base_ms) << attempts;
      if (v > 64'(cap_ms)) v = 64'(cap_ms);
      return v[TIME_W-1:0];
    endfunction

    function int lookup_slot(bit [MAC_W-1:0] mac);
      for (int i = 0; i < PEER_SLOTS; i++)
        if (slot_used[i] && slot_mac[i] == mac) return i;
      return -1;
    endfunction

    function void note_word(logic [OPC_W-1:0] op, logic [MAC_W-1:0] mac, logic [LEN_W-1:0] len,
                            logic ok, logic [TIME_W-1:0] now);
      result_t r;
      result_t retx[$];
      int idx;
      bit [TIME_W-1:0] lag;
      case (op)
        OP_SEND: begin
          r = '0;
          r.dest_mac = mac;
          r.last = 1'b1;
          if (len == 0) begin
            r.error_code = ERR_ZERO;
          end else if (len > PAYLOAD_MAX) begin
            r.error_code = ERR_LONG;
          end else begin
            idx = lookup_slot(mac);
            if (idx < 0) begin
              for (int i = 0; i < PEER_SLOTS; i++) begin
                if (!slot_used[i]) begin
                  idx = i;
                  slot_used[i] = 1'b1;
                  slot_mac[i] = mac;
                  break;
                end
              end
            end
            if (idx < 0) r.error_code = ERR_FULL;
          end
          if (r.error_code != ERR_NONE) begin
            r.kind = KIND_REJECT;
          end else begin
            slot_len[idx] = len[SLEN_W-1:0];
            armed[idx] = 1'b0;
            remaining[idx] = '0;
            due_at[idx] = '0;
            r.kind = KIND_TRANSMIT;
            r.peer_index = PIDX_W'(idx);
            r.send_length = len[SLEN_W-1:0];
          end
          awaited_results.push_back(r);
        end
        OP_COMPLETE: begin
          idx = lookup_slot(mac);
          if (idx >= 0) begin
            if (ok) begin
              armed[idx] = 1'b0;
              remaining[idx] = '0;
            end else if (slot_len[idx] != 0) begin
              if (remaining[idx] == 0) remaining[idx] = retry_limit;
              due_at[idx] = now + backoff_delay(remaining[idx]);
              armed[idx] = 1'b1;
            end
          end
        end
        OP_TICK: begin
          for (int i = 0; i < PEER_SLOTS && retx.size() < MAX_RESULTS; i++) begin
            if (!slot_used[i] || !armed[i]) continue;
            if (slot_len[i] == 0) begin
              armed[i] = 1'b0;
              continue;
            end
            lag = now - due_at[i];
            if (lag[TIME_W-1]) continue;
            if (remaining[i] == 0) begin
              armed[i] = 1'b0;
              continue;
            end
            remaining[i]--;
            r = '0;
            r.kind = KIND_RETRANSMIT;
            r.error_code = ERR_NONE;
            r.peer_index = PIDX_W'(i);
            r.dest_mac = slot_mac[i];
            r.send_length = slot_len[i];
            retx.push_back(r);
            due_at[i] = now + backoff_delay(remaining[i]);
          end
          if (retx.size() > 0) retx[retx.size()-1].last = 1'b1;
          foreach (retx[k]) awaited_results.push_back(retx[k]);
        end
        default: ;
      endcase
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [KIND_W-1:0] kind, logic [OUT_DATA_W-1:0] data, logic last);
      result_t want;
      if (awaited_results.size() == 0) begin
        $error("result word with nothing awaited: kind %0h data %0h last %0b", kind, data, last);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      check_field("kind", 64'(want.kind), 64'(kind));
      check_field("error_code", 64'(want.error_code), 64'(data[1:0]));
      check_field("peer_index", 64'(want.peer_index), 64'(data[4:2]));
      check_field("dest_mac", 64'(want.dest_mac), 64'(data[52:5]));
      check_field("send_length", 64'(want.send_length), 64'(data[60:53]));
      check_field("last", 64'(want.last), 64'(last));
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [IN_DATA_W-1:0]    s_tdata = '0;
  logic [OPC_W-1:0]        s_tuser = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   m_tdata;
  logic [KIND_W-1:0]       m_tuser;
  logic                    m_tlast;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  retry_scoreboard sb;
  bit [MAC_W-1:0] peers [PEER_SLOTS];
  bit [TIME_W-1:0] clock_ms;
  int unsigned cap_now;
  int burst_left = 0;
  int unsigned cycles = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int rx_left = 0;
  int rx_hold = 0;

  peer_retry_backoff_scheduler_top #(
    .PEER_SLOTS (PEER_SLOTS),
    .PAYLOAD_MAX(PAYLOAD_MAX)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("peer_retry_backoff_scheduler_top_tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata, m_tlast);
  end

  // receiver backpressure, with a randomly chosen mode
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(50, 300);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
          if ($urandom_range(0, 2) == 0) rx_hold = $urandom_range(1, 12);
        end
      end
    endcase
  end

  // called at a falling edge; returns at a falling edge
  task automatic push_word(logic [OPC_W-1:0] op, logic [MAC_W-1:0] mac, logic [LEN_W-1:0] len,
                           logic ok, logic [TIME_W-1:0] now);
    int gap;
    s_tuser <= op;
    s_tdata <= {5'b0, now, ok, len, mac};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_word(op, mac, len, ok, now);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(0, 15);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  // upper bits of the narrow registers carry junk that must be masked off
  task automatic program_regs(int unsigned retries, int unsigned base, int unsigned cap);
    write_reg(CFG_RETRY_LIMIT, {12'($urandom), 4'(retries)});
    write_reg(CFG_BACKOFF_BASE, {6'($urandom), 10'(base)});
    write_reg(CFG_BACKOFF_CAP, 16'(cap));
    cfg_valid <= 1'b0;
    cap_now = cap;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic directed();
    bit [MAC_W-1:0] stranger;
    stranger = 48'({$urandom(), $urandom()});
    clock_ms = 32'hFFFF_FFF0;
    push_word(OP_SEND, peers[2], 10'd0, 1'b0, clock_ms);
    push_word(OP_SEND, peers[2], 10'd1023, 1'b1, clock_ms);
    for (int i = 0; i < PEER_SLOTS; i++)
      push_word(OP_SEND, peers[i],
                (i == 0) ? 10'd1 : (i == 1) ? 10'(PAYLOAD_MAX) : 10'($urandom_range(2, 249)),
                1'b0, clock_ms);
    push_word(OP_SEND, stranger, 10'd100, 1'b0, clock_ms);
    push_word(OP_SEND, peers[3], 10'd17, 1'b0, clock_ms);
    push_word(OP_COMPLETE, stranger, 10'd0, 1'b0, clock_ms);
    push_word(OP_COMPLETE, peers[0], 10'd0, 1'b1, clock_ms);
    // retry deadline wraps past zero
    push_word(OP_COMPLETE, peers[0], 10'd0, 1'b0, clock_ms);
    push_word(OP_TICK, '0, '0, 1'b0, clock_ms + 29);
    push_word(OP_TICK, '0, '0, 1'b0, clock_ms + 30);
    for (int i = 1; i < PEER_SLOTS; i++)
      push_word(OP_COMPLETE, peers[i], 10'd0, 1'b0, clock_ms + 100);
    push_word(OP_TICK, '0, '0, 1'b0, clock_ms + 130);
    push_word(OP_TICK, '1, '1, 1'b1, 32'hFFFF_FFFF);
    push_word(OP_TICK, '0, '0, 1'b0, 32'd0);
    clock_ms += 200;
  endtask

  task automatic run_traffic(int count);
    int roll;
    bit [MAC_W-1:0] mac;
    bit [MAC_W-1:0] noise_mac;
    bit [LEN_W-1:0] len;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      mac = peers[$urandom_range(0, PEER_SLOTS-1)];
      noise_mac = 48'({$urandom(), $urandom()});
      len = 10'($urandom_range(1, PAYLOAD_MAX));
      if (roll < 20) begin
        if ($urandom_range(0, 9) == 0)
          len = $urandom_range(0, 1) ? 10'd0 : 10'($urandom_range(PAYLOAD_MAX + 1, 1023));
        push_word(OP_SEND, mac, len, 1'($urandom), clock_ms);
      end else if (roll < 25) begin
        push_word(OP_SEND, noise_mac, len, 1'($urandom), clock_ms);
      end else if (roll < 55) begin
        push_word(OP_COMPLETE, mac, len, $urandom_range(0, 3) == 0, clock_ms);
      end else if (roll < 58) begin
        push_word(OP_COMPLETE, noise_mac, len, 1'($urandom), clock_ms);
      end else if (roll < 97) begin
        if ($urandom_range(0, 19) == 0) clock_ms += $urandom();
        else clock_ms += $urandom_range(0, cap_now + 16);
        push_word(OP_TICK, noise_mac, 10'($urandom), 1'($urandom), clock_ms);
      end else begin
        push_word(OP_RESERVED, noise_mac, 10'($urandom), 1'($urandom), $urandom());
      end
    end
  endtask

  initial begin
    sb = new();
    cap_now = BACKOFF_CAP_RST;
    peers[0] = '0;
    peers[1] = '1;
    for (int i = 2; i < PEER_SLOTS; i++) peers[i] = {8'(i), 8'($urandom), 32'($urandom)};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    directed();
    for (int phase = 0; phase < 6; phase++) begin
      settle();
      case (phase)
        0: program_regs(15, 1000, 65535);
        1: program_regs(1, 1, 1);
        2: program_regs(15, 1, 65535);
        3: program_regs(1, 1000, 1);
        default: program_regs($urandom_range(1, 15), $urandom_range(1, 1000),
                              $urandom_range(1, 65535));
      endcase
      run_traffic(75);
    end
    settle();
    if (sb.errors == 0) begin
      $display("peer_retry_backoff_scheduler_top_tb passed");
    end else begin
      $display("peer_retry_backoff_scheduler_top_tb failed");
    end
    $finish;
  end

endmodule
